// ===== rtl/core/bcd_pkg.sv =====
// bounded circular deque package: sizes, codes, command and status types
`timescale 1ns / 1ps

package bcd_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_DELETE     = 3'd4,
      FN_CLEAR      = 3'd5,
      FN_DUMP       = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC,
      IDX_SUCC,
      IDX_BACK
   } idx_op_type;

   typedef enum logic [2:0] {
      PTR_NONE,
      PTR_PUSH_FRONT,
      PTR_PUSH_BACK,
      PTR_POP_FRONT,
      PTR_POP_BACK,
      PTR_DELETE,
      PTR_CLEAR
   } ptr_op_type;

   typedef enum logic [1:0] {
      WR_FRONT,
      WR_BACK,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      DS_ZERO,
      DS_RD,
      DS_DEL
   } dsel_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      idx_op_type idx_op;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cap_en;
      ptr_op_type ptr_op;
      logic       emit;
      status_type emit_status;
      dsel_type   emit_dsel;
      logic       emit_last;
   } bcd_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       out_free;
      logic       full;
      logic       empty;
      logic       match;
      logic       idx_at_back;
   } bcd_sts_type;

   // (a + b) mod DEPTH for a, b below DEPTH
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // (a - 1) mod DEPTH
   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] res;
      if (a == '0) begin
         res = IDX_W'(DEPTH - 1);
      end else begin
         res = a - IDX_W'(1);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/bcd_dp.sv =====
// bounded circular deque datapath: ring store, pointers, scan index, result register
`timescale 1ns / 1ps

module bcd_dp
   import bcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  bcd_cmd_type              cmd,
   output bcd_sts_type              sts,
   input  logic [2:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_last
);

   logic [DATA_W-1:0] ring_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] del_ff;
   logic [DATA_W-1:0] value_ff;
   logic [2:0]        func_ff;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_last_ff;

   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data, emit_data;
   logic              at_back;

   assign at_back = ({1'b0, idx_ff} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(count_ff);

   always_comb begin
      idx_in = idx_ff;
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_ZERO: idx_in = '0;
         IDX_INC:  idx_in = idx_ff + IDX_W'(1);
         IDX_SUCC: idx_in = at_back ? '0 : idx_ff + IDX_W'(1);
         IDX_BACK: idx_in = IDX_W'(count_ff - CNT_W'(1));
         default:  idx_in = idx_ff;
      endcase
   end

   assign rd_addr = wrap_add(front_ff, idx_in);

   always_comb begin
      wr_addr = wrap_dec(front_ff);
      wr_data = value_ff;
      case (cmd.wr_sel)
         WR_FRONT: wr_addr = wrap_dec(front_ff);
         WR_BACK:  wr_addr = wrap_add(front_ff, IDX_W'(count_ff));
         WR_SHIFT: begin
            wr_addr = wrap_add(front_ff, idx_ff - IDX_W'(1));
            wr_data = rd_data_ff;
         end
         default:  wr_addr = wrap_dec(front_ff);
      endcase
   end

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      case (cmd.ptr_op)
         PTR_NONE: ;
         PTR_PUSH_FRONT: begin
            front_in = wrap_dec(front_ff);
            count_in = count_ff + CNT_W'(1);
         end
         PTR_PUSH_BACK: count_in = count_ff + CNT_W'(1);
         PTR_POP_FRONT: begin
            front_in = wrap_add(front_ff, IDX_W'(1));
            count_in = count_ff - CNT_W'(1);
         end
         PTR_POP_BACK: count_in = count_ff - CNT_W'(1);
         PTR_DELETE: begin
            if (idx_ff == '0) begin
               front_in = wrap_add(front_ff, IDX_W'(1));
            end
            count_in = count_ff - CNT_W'(1);
         end
         PTR_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.emit_dsel)
         DS_ZERO: emit_data = '0;
         DS_RD:   emit_data = rd_data_ff;
         DS_DEL:  emit_data = del_ff;
         default: emit_data = '0;
      endcase
   end

   // ring store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.cap_en) begin
         del_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_data_ff   <= emit_data;
         rsp_count_ff  <= count_in;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.func        = func_ff;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign sts.full        = count_ff >= CNT_W'(DEPTH);
   assign sts.empty       = count_ff == '0;
   assign sts.match       = rd_data_ff == value_ff;
   assign sts.idx_at_back = at_back;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.ptr_op == PTR_PUSH_FRONT || cmd.ptr_op == PTR_PUSH_BACK) |-> !sts.full)
      else $error("push applied to a full deque");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.ptr_op == PTR_POP_FRONT || cmd.ptr_op == PTR_POP_BACK
       || cmd.ptr_op == PTR_DELETE) |-> !sts.empty)
      else $error("removal applied to an empty deque");

endmodule

// ===== rtl/core/bcd_ctrl.sv =====
// bounded circular deque controller state machine
`timescale 1ns / 1ps

module bcd_ctrl
   import bcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bcd_sts_type sts,
   output bcd_cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_POP    = 8'b0000_0100,
      S_DUMP   = 8'b0000_1000,
      S_SRCH   = 8'b0001_0000,
      S_TAKE   = 8'b0010_0000,
      S_SHIFT  = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.rd_en       = 1'b0;
      cmd.idx_op      = IDX_HOLD;
      cmd.wr_en       = 1'b0;
      cmd.wr_sel      = WR_FRONT;
      cmd.cap_en      = 1'b0;
      cmd.ptr_op      = PTR_NONE;
      cmd.emit        = 1'b0;
      cmd.emit_status = ST_OK;
      cmd.emit_dsel   = DS_ZERO;
      cmd.emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.func)
               FN_PUSH_FRONT, FN_PUSH_BACK: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                     if (sts.full) begin
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.wr_en = 1'b1;
                        if (sts.func == FN_PUSH_FRONT) begin
                           cmd.wr_sel = WR_FRONT;
                           cmd.ptr_op = PTR_PUSH_FRONT;
                        end else begin
                           cmd.wr_sel = WR_BACK;
                           cmd.ptr_op = PTR_PUSH_BACK;
                        end
                     end
                  end
               end
               FN_POP_FRONT, FN_POP_BACK, FN_DELETE, FN_DUMP: begin
                  if (sts.empty) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.idx_op = (sts.func == FN_POP_BACK) ? IDX_BACK : IDX_ZERO;
                     if (sts.func == FN_DELETE) begin
                        state_in = S_SRCH;
                     end else if (sts.func == FN_DUMP) begin
                        state_in = S_DUMP;
                     end else begin
                        state_in = S_POP;
                     end
                  end
               end
               FN_CLEAR: begin
                  if (sts.out_free) begin
                     cmd.emit   = 1'b1;
                     cmd.ptr_op = PTR_CLEAR;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_POP: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_dsel = DS_RD;
               cmd.ptr_op    = (sts.func == FN_POP_FRONT) ? PTR_POP_FRONT : PTR_POP_BACK;
               state_in      = S_IDLE;
            end
         end
         S_DUMP: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_dsel = DS_RD;
               cmd.emit_last = sts.idx_at_back;
               if (sts.idx_at_back) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.idx_op = IDX_INC;
               end
            end
         end
         S_SRCH: begin
            if (sts.match) begin
               cmd.rd_en  = 1'b1;
               cmd.idx_op = IDX_SUCC;
               state_in   = S_TAKE;
            end else if (!sts.idx_at_back) begin
               cmd.rd_en  = 1'b1;
               cmd.idx_op = IDX_INC;
            end else if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_NOTFOUND;
               state_in        = S_IDLE;
            end
         end
         S_TAKE: begin
            // removed word is in the read register, successor index is held
            cmd.cap_en = 1'b1;
            if (sts.idx_at_back) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.idx_op = IDX_INC;
               state_in   = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // close the gap one entry a cycle
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            if (sts.idx_at_back) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.idx_op = IDX_INC;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_dsel = DS_DEL;
               cmd.ptr_op    = PTR_DELETE;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DECODE)
      else $error("accepted transaction not decoded");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result written while output register occupied");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> state_ff == S_IDLE)
      else $error("final result not followed by idle");

endmodule

// ===== rtl/core/bounded_circular_deque.sv =====
// bounded circular deque top level: controller and datapath
//
// Usage: each request transaction on req_ carries one command (req_func) and a
// word (req_value). The block answers on rsp_ with status, data, the entry count
// after the command and a last flag. Every command gives one response except a
// dump of a non-empty deque, which gives one response per entry, front first,
// with rsp_last on the final one.
// Timing: one command at a time. A request is taken only while the controller
// is idle. Push, clear and empty or full cases respond from the decode state,
// pops from the pop state. A dump gives its first response from the dump
// state, then one per cycle while the receiver keeps up. Delete-after scans
// the ring store one entry a cycle through its single registered read port,
// then shifts the entries behind the removed one one per cycle. Throughput is
// set by the controller returning to idle; a new request can be taken while
// the previous response still waits in the output register.
// Reset empties the deque (front index and count to zero); store contents are
// undefined until written and no clearing pass is needed.
// Receiver stall: while rsp_valid is held without rsp_ready the controller
// waits in its state before producing the next response; nothing is lost.

`timescale 1ns / 1ps

module bounded_circular_deque
   import bcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_last
);

   bcd_cmd_type cmd;
   bcd_sts_type sts;

   bcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for bounded_circular_deque with driver, monitor and deque predictor
`timescale 1ns / 1ps

module tb;
   import bcd_pkg::*;

   localparam logic [2:0] FN_UNUSED = 3'd7;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam int RANDOM_CMDS = 400;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [2:0]               func;
      logic signed [DATA_W-1:0] value;
      int                       gap;
      bit                       drain;
   } deque_cmd_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic [CNT_W-1:0]         count;
      logic                     last;
   } deque_answer_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_func = FN_CLEAR;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_last;

   deque_cmd_type            cmd_q[$];
   deque_answer_type         due_answers[$];
   logic signed [DATA_W-1:0] ring_words[DEPTH];
   logic signed [DATA_W-1:0] key_pool[8];
   int                       head_slot = 0;
   int                       fill = 0;
   int                       faults = 0;
   int                       cycle_no = 0;
   int                       answers_seen = 0;
   int                       hold_left = 0;
   int                       gap_left = 0;
   bit                       armed = 0;
   deque_cmd_type            cur;

   bounded_circular_deque u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int slot_of(input int k);
      return (head_slot + k) % DEPTH;
   endfunction

   function automatic void apply_deque_cmd(input logic [2:0] f,
                                           input logic signed [DATA_W-1:0] v);
      deque_answer_type a;
      int k;
      int hit;
      int pos;
      a.status = ST_OK;
      a.data = '0;
      a.last = 1'b1;
      case (f)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               a.status = ST_FULL;
            end else begin
               if (f == FN_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring_words[head_slot] = v;
               end else begin
                  ring_words[slot_of(fill)] = v;
               end
               fill++;
            end
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (fill == 0) begin
               a.status = ST_EMPTY;
            end else begin
               if (f == FN_POP_FRONT) begin
                  a.data = ring_words[head_slot];
                  head_slot = (head_slot + 1) % DEPTH;
               end else begin
                  a.data = ring_words[slot_of(fill - 1)];
               end
               fill--;
            end
         end
         FN_DELETE: begin
            if (fill == 0) begin
               a.status = ST_EMPTY;
            end else begin
               hit = -1;
               for (k = 0; k < fill; k++) begin
                  if (hit < 0 && ring_words[slot_of(k)] == v) hit = k;
               end
               if (hit < 0) begin
                  a.status = ST_NOTFOUND;
               end else begin
                  pos = (hit + 1) % fill;
                  a.data = ring_words[slot_of(pos)];
                  if (pos == 0) begin
                     head_slot = (head_slot + 1) % DEPTH;
                  end else begin
                     for (k = pos; k + 1 < fill; k++) begin
                        ring_words[slot_of(k)] = ring_words[slot_of(k + 1)];
                     end
                  end
                  fill--;
               end
            end
         end
         FN_CLEAR: begin
            head_slot = 0;
            fill = 0;
         end
         FN_DUMP: begin
            if (fill == 0) begin
               a.status = ST_EMPTY;
            end else begin
               for (k = 0; k < fill - 1; k++) begin
                  due_answers.push_back('{ST_OK, ring_words[slot_of(k)], CNT_W'(fill), 1'b0});
               end
               a.data = ring_words[slot_of(fill - 1)];
            end
         end
         default: begin
         end
      endcase
      a.count = CNT_W'(fill);
      due_answers.push_back(a);
   endfunction

   function automatic void check_field(input string what, input longint want,
                                       input longint got);
      if (want != got) begin
         faults++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
   endfunction

   function automatic void add_cmd(input logic [2:0] f, input logic signed [DATA_W-1:0] v,
                                   input bit drain);
      deque_cmd_type c;
      c.func = f;
      c.value = v;
      c.gap = ((cmd_q.size() / 50) % 4 == 1) ? 0 : $urandom_range(0, 7);
      c.drain = drain;
      cmd_q.push_back(c);
   endfunction

   function automatic logic signed [DATA_W-1:0] draw_word();
      if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         armed = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) apply_deque_cmd(req_func, req_value);
         if (!req_valid || req_ready) begin
            if (!armed && cmd_q.size() != 0) begin
               cur = cmd_q.pop_front();
               armed = 1;
               gap_left = cur.gap;
            end
            if (armed && gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (armed && !(cur.drain && due_answers.size() != 0)) begin
               req_valid <= 1'b1;
               req_func <= cur.func;
               req_value <= cur.value;
               armed = 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      deque_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               faults++;
               $display("%0t: unexpected transaction, status %0d data %0d count %0d last %0d",
                        $time, rsp_status, rsp_data, rsp_count, rsp_last);
            end else begin
               want = due_answers.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("data", want.data, rsp_data);
               check_field("count", want.count, rsp_count);
               check_field("last", want.last, rsp_last);
            end
            answers_seen++;
            hold_left = ((answers_seen / 60) % 4 == 3) ? 0 : $urandom_range(0, 7);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_no++;
      if (cycle_no > CYCLE_LIMIT) begin
         $display("bounded_circular_deque regression: fail");
         $finish;
      end
   end

   initial begin
      int n;
      int mood;
      int roll;
      int grow_pct;
      logic [2:0] f;
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] tail_word;

      key_pool[0] = '0;
      key_pool[1] = -1;
      key_pool[2] = WORD_MIN;
      key_pool[3] = WORD_MAX;
      key_pool[4] = 1;
      for (n = 5; n < 8; n++) key_pool[n] = $urandom;

      // directed: empty cases, unused code, self-matching single entry
      add_cmd(FN_POP_FRONT, 0, 1'b0);
      add_cmd(FN_DELETE, 5, 1'b0);
      add_cmd(FN_DUMP, 0, 1'b0);
      add_cmd(FN_UNUSED, -1, 1'b0);
      add_cmd(FN_PUSH_BACK, WORD_MAX, 1'b0);
      add_cmd(FN_DELETE, WORD_MAX, 1'b0);
      // fill to full from both ends
      tail_word = '0;
      for (n = 0; n < DEPTH; n++) begin
         case (n)
            0: v = WORD_MAX;
            1: v = WORD_MIN;
            2: v = -1;
            3: v = '0;
            default: v = $urandom;
         endcase
         add_cmd((n % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, v, 1'b0);
         if (n % 2 == 0) tail_word = v;
      end
      add_cmd(FN_PUSH_FRONT, 7, 1'b0);
      add_cmd(FN_DELETE, tail_word, 1'b0);
      add_cmd(FN_DELETE, 32'sh1357_9bdf, 1'b0);
      add_cmd(FN_POP_FRONT, 0, 1'b0);
      add_cmd(FN_POP_BACK, 0, 1'b0);
      add_cmd(FN_DUMP, 0, 1'b0);
      add_cmd(FN_CLEAR, 0, 1'b0);

      // random phases: grow, shrink, mixed
      for (n = 0; n < RANDOM_CMDS; n++) begin
         mood = (n / 40) % 3;
         grow_pct = (mood == 0) ? 75 : (mood == 1) ? 20 : 45;
         roll = $urandom_range(0, 99);
         if (roll < grow_pct) begin
            f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 38) f = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            else if (roll < 76) f = FN_DELETE;
            else if (roll < 92) f = FN_DUMP;
            else if (roll < 97) f = (mood == 2) ? FN_CLEAR : FN_DUMP;
            else f = FN_UNUSED;
         end
         add_cmd(f, draw_word(), (n % 100 == 0));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || armed || req_valid || due_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);
      faults += due_answers.size();
      if (faults == 0) begin
         $display("bounded_circular_deque regression: pass");
      end else begin
         $display("bounded_circular_deque regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bcd_pkg.sv
rtl/core/bcd_dp.sv
rtl/core/bcd_ctrl.sv
rtl/core/bounded_circular_deque.sv
tb/sv/tb.sv
